// ----- src/assert_macros.svh -----
// Assertion helpers, included by the timed command sorted queue unit.
// Each macro samples on the rising edge of i_clk and is disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// When the antecedent holds, the consequent holds at the following clock edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/tcsq_pkg.sv -----
// ----------------------------------------------------------------------------
// Timed command sorted queue package
// Table size, field widths, slot layout and operation codes.
// ----------------------------------------------------------------------------
package tcsq_pkg;

    localparam int NumEntries = 16;
    localparam int IdxW       = (NumEntries > 1) ? $clog2(NumEntries) : 1;
    localparam int CntW       = $clog2(NumEntries + 1);

    localparam int ByteW   = 8;
    localparam int AddrW   = 32;
    localparam int FuncW   = 2;
    localparam int CountW  = 5;

    localparam logic [ByteW-1:0] EmptyByte = 8'hFF;

    localparam logic [FuncW-1:0] FuncInsert = 2'd0;
    localparam logic [FuncW-1:0] FuncRemove = 2'd1;
    localparam logic [FuncW-1:0] FuncClear  = 2'd2;

    // One table slot, 64 bits, content in the top byte.
    typedef struct packed {
        logic [ByteW-1:0] content;
        logic [ByteW-1:0] minutes;
        logic [ByteW-1:0] detail;
        logic [AddrW-1:0] address;
        logic [ByteW-1:0] packets;
    } t_slot;

    localparam int SlotW = $bits(t_slot);

endpackage

// ----- src/tcsq_alu.sv -----
// ----------------------------------------------------------------------------
// Shared time unit
// Saturating subtraction of two minute counts and a compare of the result.
// ----------------------------------------------------------------------------
module tcsq_alu (
    input  logic [tcsq_pkg::ByteW-1:0] i_minuend,
    input  logic [tcsq_pkg::ByteW-1:0] i_subtrahend,
    input  logic [tcsq_pkg::ByteW-1:0] i_limit,
    output logic [tcsq_pkg::ByteW-1:0] o_diff,
    output logic                       o_above
);
    import tcsq_pkg::*;

    logic [ByteW:0] w_sub;

    // The borrow bit tells us the result would go negative.
    assign w_sub   = {1'b0, i_minuend} - {1'b0, i_subtrahend};
    assign o_diff  = w_sub[ByteW] ? '0 : w_sub[ByteW-1:0];
    assign o_above = (o_diff > i_limit);

endmodule

// ----- src/timed_command_sorted_queue_unit.sv -----
// ----------------------------------------------------------------------------
// Timed command sorted queue unit
// A table of timed commands kept in ascending order of minutes-to-run, walked
// one slot per cycle by a small sequencer around a shared time unit.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake                 | Payload
//   --------+-----------+---------------------------+-----------------------
//   in      | input     | i_in_valid / o_in_ready   | func, elapsed, command
//   out     | output    | o_out_valid / i_out_ready | status, count, head
//
// An insert walks the entries in S_INS and S_INS_END, a remove in S_RHD and
// S_RMV; then S_HEAD reads the head and S_OUT loads the result register. An
// insert into an empty or a full table, a remove from an empty table, a clear
// and an unused code go straight to S_HEAD. The walk is set by the single read
// port of the slot memory, which the sequencer steps one slot per cycle through
// the shared subtract-and-compare unit, and the input is ready again as the
// result is loaded. Reset is synchronous and active low and leaves the table
// empty and idle; the slot memory itself is not cleared, as slots at and
// beyond the entry count are never reported. The input side is ready only
// while the sequencer is idle; a result waiting in the output register does
// not hold off the next beat, only the delivery of its result, and the
// sequencer then waits in its last state until the register is free.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module timed_command_sorted_queue_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [tcsq_pkg::FuncW-1:0]  i_func,
    input  logic [tcsq_pkg::ByteW-1:0]  i_elapsed_min,
    input  logic [tcsq_pkg::ByteW-1:0]  i_cmd_content,
    input  logic [tcsq_pkg::ByteW-1:0]  i_cmd_time,
    input  logic [tcsq_pkg::ByteW-1:0]  i_cmd_detail,
    input  logic [tcsq_pkg::AddrW-1:0]  i_cmd_address,
    input  logic [tcsq_pkg::ByteW-1:0]  i_cmd_packets,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_status,
    output logic                        o_in_use,
    output logic [tcsq_pkg::CountW-1:0] o_entry_count,
    output logic [tcsq_pkg::ByteW-1:0]  o_head_content,
    output logic [tcsq_pkg::ByteW-1:0]  o_head_time,
    output logic [tcsq_pkg::ByteW-1:0]  o_head_detail,
    output logic [tcsq_pkg::AddrW-1:0]  o_head_address,
    output logic [tcsq_pkg::ByteW-1:0]  o_head_packets
);
    import tcsq_pkg::*;

    // Sequencer states.
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_INS     = 3'd1;
    localparam logic [2:0] S_INS_END = 3'd2;
    localparam logic [2:0] S_RHD     = 3'd3;
    localparam logic [2:0] S_RMV     = 3'd4;
    localparam logic [2:0] S_HEAD    = 3'd5;
    localparam logic [2:0] S_OUT     = 3'd6;

    // Control state.
    logic [2:0]      r_state,  n_state;
    logic [CntW-1:0] r_occ,    n_occ;
    logic            r_active, n_active;
    logic            r_placed, n_placed;
    logic            r_out_valid, n_out_valid;

    // Payload registers.
    logic [CntW-1:0]  r_idx,     n_idx;
    logic             r_status,  n_status;
    t_slot            r_item,    n_item;
    t_slot            r_carry,   n_carry;
    logic [ByteW-1:0] r_elapsed, n_elapsed;
    logic [ByteW-1:0] r_ht,      n_ht;
    t_slot            r_out_slot, n_out_slot;
    logic             r_out_status, n_out_status;
    logic             r_out_use,    n_out_use;
    logic [CntW-1:0]  r_out_occ,    n_out_occ;

    // Slot memory, one write and one registered read per cycle.
    t_slot            mem [NumEntries];
    t_slot            r_rd_data;
    logic             w_rd_en, w_wr_en;
    logic [IdxW-1:0]  w_rd_addr, w_wr_addr;
    t_slot            w_wr_data;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_data <= mem[w_rd_addr];
        end
    end

    // The shared time unit ages an entry by the elapsed minutes during an
    // insert, or by the removed head's time during a remove, and compares the
    // aged time against the new command's time.
    logic [ByteW-1:0] w_diff;
    logic             w_above;
    t_slot            w_aged;

    tcsq_alu u_alu (
        .i_minuend    (r_rd_data.minutes),
        .i_subtrahend ((r_state == S_RMV) ? r_ht : r_elapsed),
        .i_limit      (r_item.minutes),
        .o_diff       (w_diff),
        .o_above      (w_above)
    );

    always_comb begin
        w_aged         = r_rd_data;
        w_aged.minutes = w_diff;
    end

    logic            w_in_acc;
    logic            w_out_free;
    logic [CntW-1:0] w_idx_inc;
    logic [CntW-1:0] w_idx_dec;
    t_slot           w_new_item;

    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_idx_inc  = r_idx + CntW'(1);
    assign w_idx_dec  = r_idx - CntW'(1);

    always_comb begin
        w_new_item.content = i_cmd_content;
        w_new_item.minutes = i_cmd_time;
        w_new_item.detail  = i_cmd_detail;
        w_new_item.address = i_cmd_address;
        w_new_item.packets = i_cmd_packets;
    end

    always_comb begin
        n_state      = r_state;
        n_occ        = r_occ;
        n_active     = r_active;
        n_placed     = r_placed;
        n_out_valid  = r_out_valid;
        n_idx        = r_idx;
        n_status     = r_status;
        n_item       = r_item;
        n_carry      = r_carry;
        n_elapsed    = r_elapsed;
        n_ht         = r_ht;
        n_out_slot   = r_out_slot;
        n_out_status = r_out_status;
        n_out_use    = r_out_use;
        n_out_occ    = r_out_occ;
        w_rd_en      = 1'b0;
        w_rd_addr    = '0;
        w_wr_en      = 1'b0;
        w_wr_addr    = '0;
        w_wr_data    = r_item;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_item    = w_new_item;
                    n_elapsed = i_elapsed_min;
                    n_status  = 1'b0;
                    n_idx     = '0;
                    n_placed  = 1'b0;
                    n_state   = S_HEAD;
                    unique case (i_func)
                        FuncInsert: begin
                            n_active = 1'b1;
                            if (r_occ >= CntW'(NumEntries)) begin
                                n_status = 1'b1;
                            end else if (r_occ == '0) begin
                                w_wr_en   = 1'b1;
                                w_wr_data = w_new_item;
                                n_occ     = CntW'(1);
                            end else begin
                                w_rd_en = 1'b1;
                                n_state = S_INS;
                            end
                        end
                        FuncRemove: begin
                            if (r_occ != '0) begin
                                w_rd_en = 1'b1;
                                n_state = S_RHD;
                            end
                        end
                        FuncClear: begin
                            n_occ    = '0;
                            n_active = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_INS: begin
                // The new command goes before the first entry whose aged time
                // is strictly greater; later entries ripple up one slot.
                w_wr_en   = 1'b1;
                w_wr_addr = r_idx[IdxW-1:0];
                if (!r_placed && w_above) begin
                    w_wr_data = r_item;
                    n_carry   = w_aged;
                    n_placed  = 1'b1;
                end else if (r_placed) begin
                    w_wr_data = r_carry;
                    n_carry   = w_aged;
                end else begin
                    w_wr_data = w_aged;
                end
                n_idx = w_idx_inc;
                if (w_idx_inc < r_occ) begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = w_idx_inc[IdxW-1:0];
                end else begin
                    n_state = S_INS_END;
                end
            end
            S_INS_END: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_occ[IdxW-1:0];
                w_wr_data = r_placed ? r_carry : r_item;
                n_occ     = r_occ + CntW'(1);
                n_state   = S_HEAD;
            end
            S_RHD: begin
                n_ht = r_rd_data.minutes;
                if (r_occ == CntW'(1)) begin
                    n_occ   = '0;
                    n_state = S_HEAD;
                end else begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = IdxW'(1);
                    n_idx     = CntW'(1);
                    n_state   = S_RMV;
                end
            end
            S_RMV: begin
                w_wr_en   = 1'b1;
                w_wr_addr = w_idx_dec[IdxW-1:0];
                w_wr_data = w_aged;
                n_idx     = w_idx_inc;
                if (w_idx_inc < r_occ) begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = w_idx_inc[IdxW-1:0];
                end else begin
                    n_occ   = r_occ - CntW'(1);
                    n_state = S_HEAD;
                end
            end
            S_HEAD: begin
                w_rd_en = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_use    = r_active;
                    n_out_occ    = r_occ;
                    // An empty table reports every head field as all ones.
                    if (r_occ == '0) begin
                        n_out_slot = '1;
                    end else begin
                        n_out_slot = r_rd_data;
                    end
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '0;
            r_active    <= 1'b0;
            r_placed    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_active    <= n_active;
            r_placed    <= n_placed;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_status     <= n_status;
        r_item       <= n_item;
        r_carry      <= n_carry;
        r_elapsed    <= n_elapsed;
        r_ht         <= n_ht;
        r_out_slot   <= n_out_slot;
        r_out_status <= n_out_status;
        r_out_use    <= n_out_use;
        r_out_occ    <= n_out_occ;
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_in_use       = r_out_use;
    assign o_entry_count  = CountW'(r_out_occ);
    assign o_head_content = r_out_slot.content;
    assign o_head_time    = r_out_slot.minutes;
    assign o_head_detail  = r_out_slot.detail;
    assign o_head_address = r_out_slot.address;
    assign o_head_packets = r_out_slot.packets;

    `ASSERT_ALWAYS(a_occ_bound, r_occ <= CntW'(NumEntries), "entry count above table size")
    `ASSERT_ALWAYS(a_walk_in_range, (r_state != S_INS && r_state != S_RMV) || r_idx < r_occ, "slot walk beyond occupied entries")
    `ASSERT_NEXT(a_clear_empties, w_in_acc && i_func == FuncClear, r_occ == '0 && !r_active, "clear left entries or activity behind")
    `ASSERT_NEXT(a_full_refused, w_in_acc && i_func == FuncInsert && r_occ == CntW'(NumEntries), r_status && r_occ == CntW'(NumEntries), "insert into full table not refused")

endmodule
